>>> sv/set_assoc_lru_cache_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative LRU cache tag store
// Each macro builds one labelled concurrent assertion. It is clocked on clk
// and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SALC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("set_assoc_lru_cache: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SALC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("set_assoc_lru_cache: next-cycle check failed");

`endif

>>> sv/salc_pkg.sv
// ----------------------------------------------------------------------------
// Set-associative LRU cache package
// Geometry constants, request and response types and the command bundle
// that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package salc_pkg;

	// Number of sets. It must be a power of two, so that the set index is the
	// low bits of the block number and the tag is the rest.
	localparam int unsigned SETS       = 4;
	localparam int unsigned SET_W      = $clog2(SETS);
	localparam int unsigned BLOCK_BITS = 16;
	localparam int unsigned TAG_W      = BLOCK_BITS - SET_W;
	localparam int unsigned DEF_WAYS   = 2;

	// Request actions.
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_STORE = 2'd1;
	localparam logic [1:0] ACT_PROBE = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] block_number;
	} req_item_t;

	typedef struct packed {
		logic hit;
		logic way_used;
		logic writeback;
	} rsp_item_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} salc_cmd_t;

endpackage

>>> sv/set_assoc_lru_cache.sv
// An accepted request is latched together with its set row; the lookup
// state then commits it to the response register and raises rsp_valid.
// A new request is taken only after the previous one has committed, since
// the set row memory is read on accept and written back by the lookup cycle.
// A stalled response holds the lookup cycle until the response register frees.
// Reset clears all valid bits at once; there is no clearing pass, and the
// tag, age and dirty memory is left unreset.
// ----------------------------------------------------------------------------
// Set-associative LRU cache tag store
// Each request carries a block number and an action (load, store or probe).
// The low bits of the block number select the set and the rest form the tag.
// All ways of the set are compared together. A load or store that misses
// takes the first invalid way, otherwise the least recently used one, and
// reports whether a valid dirty line was evicted. Loads and stores make the
// line the most recently used; a store marks it dirty, a load hit keeps the
// mark. A probe reports hit and way and changes nothing.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache import salc_pkg::*; #(
	parameter int unsigned WAYS = DEF_WAYS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	// Command bundle from the sequencer: capture latches the request and
	// launches the set row read; commit writes the updated row back for a
	// load or store and loads the response register.
	salc_cmd_t cmd;

	// The controller owns the handshakes and the response valid flag.
	salc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// The datapath holds the set rows, the valid bits and the response
	// payload register.
	salc_dp #(
		.WAYS (WAYS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

>>> sv/salc_ctrl.sv
// ----------------------------------------------------------------------------
// Set-associative LRU cache controller
// Two-state sequencer: it takes a request, then commits the lookup once the
// response register is free.
// ----------------------------------------------------------------------------
`include "set_assoc_lru_cache_assert.svh"

module salc_ctrl import salc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output salc_cmd_t cmd
);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_LOOKUP = 1'b1;

	logic state_q;
	logic state_d;
	logic rsp_valid_q;
	logic accept;
	logic rsp_free;

	assign req_stall = (state_q == ST_LOOKUP);
	assign accept    = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	assign cmd.capture = accept;
	assign cmd.commit  = (state_q == ST_LOOKUP) && rsp_free;
	assign rsp_valid   = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`SALC_ASSERT_NEXT(a_accept_to_lookup, req_valid && !req_stall, state_q == ST_LOOKUP)
	`SALC_ASSERT_NEXT(a_lookup_waits, (state_q == ST_LOOKUP) && rsp_valid && rsp_stall, state_q == ST_LOOKUP)
	`SALC_ASSERT_NEXT(a_commit_shows, cmd.commit, rsp_valid)
	`SALC_ASSERT_SAME(a_no_overlap, cmd.capture, !cmd.commit)

endmodule

>>> sv/salc_dp.sv
// ----------------------------------------------------------------------------
// Set-associative LRU cache datapath
// Set row memory, valid bits, tag compare, victim choice and recency update.
// ----------------------------------------------------------------------------
module salc_dp import salc_pkg::*; #(
	parameter int unsigned WAYS = DEF_WAYS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  salc_cmd_t cmd,
	input  req_item_t req,
	output rsp_item_t rsp
);

	localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam logic [WAY_W-1:0] LRU_RANK = WAY_W'(WAYS - 1);

	typedef struct packed {
		logic [WAYS-1:0][TAG_W-1:0] tag;
		logic [WAYS-1:0][WAY_W-1:0] rank;
		logic [WAYS-1:0]            dirty;
	} row_t;

	row_t            mem_q [SETS];
	logic [WAYS-1:0] valid_q [SETS];

	req_item_t        req_s1;
	row_t             row_s1;
	row_t             row_n;
	rsp_item_t        rsp_q;
	logic [SET_W-1:0] set_in;
	logic [SET_W-1:0] set_s1;
	logic [TAG_W-1:0] tag_s1;
	logic [WAYS-1:0]  vld;
	logic [WAYS-1:0]  vld_n;
	logic [WAYS-1:0]  match;
	logic             hit;
	logic             free_any;
	logic             update;
	logic             store;
	logic             writeback;
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] free_way;
	logic [WAY_W-1:0] lru_way;
	logic [WAY_W-1:0] way_sel;

	assign set_in = req.block_number[SET_W-1:0];
	assign set_s1 = req_s1.block_number[SET_W-1:0];
	assign tag_s1 = req_s1.block_number[BLOCK_BITS-1:SET_W];
	assign vld    = valid_q[set_s1];
	assign update = req_s1.action inside {ACT_LOAD, ACT_STORE};
	assign store  = (req_s1.action == ACT_STORE);

	// Compare all ways of the set and pick the hit, free and LRU ways.
	// In a full set the ages form a permutation, so the oldest line has the
	// largest possible age.
	always_comb begin
		logic found_hit;
		logic found_free;
		logic found_lru;
		found_hit  = 1'b0;
		found_free = 1'b0;
		found_lru  = 1'b0;
		hit_way    = '0;
		free_way   = '0;
		lru_way    = '0;
		for (int k = 0; k < WAYS; k++) begin
			match[k] = vld[k] && (row_s1.tag[k] == tag_s1);
			if (match[k] && !found_hit) begin
				hit_way   = WAY_W'(k);
				found_hit = 1'b1;
			end
			if (!vld[k] && !found_free) begin
				free_way   = WAY_W'(k);
				found_free = 1'b1;
			end
			if ((row_s1.rank[k] == LRU_RANK) && !found_lru) begin
				lru_way   = WAY_W'(k);
				found_lru = 1'b1;
			end
		end
		hit      = found_hit;
		free_any = found_free;
	end

	always_comb begin
		if (hit) begin
			way_sel = hit_way;
		end else if (update) begin
			way_sel = free_any ? free_way : lru_way;
		end else begin
			way_sel = '0;
		end
	end

	assign writeback = update && !hit && vld[way_sel] && row_s1.dirty[way_sel];
	assign vld_n     = vld | (WAYS'(1) << way_sel);

	// New row contents: age the younger lines, install the tag on a miss and
	// track the dirty mark.
	always_comb begin
		row_n = row_s1;
		for (int k = 0; k < WAYS; k++) begin
			if ((WAY_W'(k) != way_sel) && vld[k] &&
				(!hit || (row_s1.rank[k] < row_s1.rank[way_sel]))) begin
				row_n.rank[k] = row_s1.rank[k] + 1'b1;
			end
		end
		row_n.rank[way_sel] = '0;
		if (!hit) begin
			row_n.tag[way_sel]   = tag_s1;
			row_n.dirty[way_sel] = 1'b0;
		end
		if (store) begin
			row_n.dirty[way_sel] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_s1 <= req;
			row_s1 <= mem_q[set_in];
		end
		if (cmd.commit && update) begin
			mem_q[set_s1] <= row_n;
		end
		if (cmd.commit) begin
			rsp_q.hit       <= hit;
			rsp_q.way_used  <= way_sel[0];
			rsp_q.writeback <= writeback;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SETS; s++) begin
				valid_q[s] <= '0;
			end
		end else if (cmd.commit && update) begin
			valid_q[set_s1] <= vld_n;
		end
	end

	assign rsp = rsp_q;

endmodule
